FILE: design/ata_pkg.sv
package ata_pkg;

    localparam int unsigned WINDOW_LENGTH = 5;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned AVG_W    = 12;
    localparam int unsigned THR_W    = 12;
    localparam int unsigned INTV_W   = 16;
    localparam int unsigned DUR_W    = 32;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 48;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL  = 1'b1;

    localparam logic [THR_W-1:0]  THR_RESET  = 12'd1000;
    localparam logic [INTV_W-1:0] INTV_RESET = 16'd1000;

    localparam int unsigned SAMPLE_MAX = 4095;
    localparam int unsigned MV_NUM     = 3675;
    localparam int unsigned MV_DEN     = 4095;

    localparam int unsigned POS_W   = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int unsigned SUM_MAX = SAMPLE_MAX * WINDOW_LENGTH;
    localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);

    // full-scale divisor of the average: 4095 * window length
    localparam int unsigned DEN = MV_DEN * WINDOW_LENGTH;

    localparam longint unsigned P_MAX = longint'(SUM_MAX) * longint'(MV_NUM);
    localparam int unsigned     P_W   = $clog2(P_MAX + 1);

    // hysteresis: sum*3675*20 against thr*DEN*21 and thr*DEN*19
    localparam longint unsigned THR_HI_K  = longint'(DEN) * 21;
    localparam longint unsigned THR_LO_K  = longint'(DEN) * 19;
    localparam longint unsigned SCALE_MAX = P_MAX * 20;
    localparam longint unsigned THR_MAX   = longint'(SAMPLE_MAX) * THR_HI_K;
    localparam int unsigned     CMP_W     = $clog2(((SCALE_MAX > THR_MAX) ? SCALE_MAX : THR_MAX)
                                                   + 1);

    // floor reciprocal of DEN; the quotient estimate is low by at most one
    localparam int unsigned     RECIP_K = P_W;
    localparam longint unsigned RECIP_M = (longint'(1) << RECIP_K) / DEN;
    localparam int unsigned     M_W     = $clog2(RECIP_M + 1);

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             cleared;
        logic             raised;
        logic             active;
    } alarm_t;

endpackage

FILE: design/averaged_threshold_alarm.sv
// Pipeline: after its sample transfer, a result passes the sum, product, alarm/quotient
// and correction stages in order; the correction writes the output register.
// Throughput: one sample per cycle; the running sum and the alarm state each update
// once per sample, and every stage holds while the next one is full and stalled.
// Reset (rst_n low, asynchronous): sample ring, sum, alarm and duration cleared,
// threshold 1000 mV, interval 1000 ms, no result pending.
module averaged_threshold_alarm
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ata_pkg::IN_DATA_W-1:0]     s_tdata,   // raw_sample[11:0], zero pad
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // average_mv[11:0], alarm_active, alarm_raised, alarm_cleared,
    // alarm_duration_ms[31:0], zero pad
    output logic [ata_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ata_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ata_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned SW  = ata_pkg::SAMPLE_W;
    localparam int unsigned PW  = ata_pkg::POS_W;
    localparam int unsigned SMW = ata_pkg::SUM_W;
    localparam int unsigned PRW = ata_pkg::P_W;
    localparam int unsigned CW  = ata_pkg::CMP_W;
    localparam int unsigned AW  = ata_pkg::AVG_W;
    localparam int unsigned DW  = ata_pkg::DUR_W;
    localparam int unsigned MW  = ata_pkg::M_W;

    localparam logic [MW-1:0]  RECIP_M_C = MW'(ata_pkg::RECIP_M);
    localparam logic [PRW-1:0] DEN_C     = PRW'(ata_pkg::DEN);
    localparam logic [CW-1:0]  THR_HI_C  = CW'(ata_pkg::THR_HI_K);
    localparam logic [CW-1:0]  THR_LO_C  = CW'(ata_pkg::THR_LO_K);

    // configuration
    logic [ata_pkg::THR_W-1:0]  thr_reg;
    logic [ata_pkg::INTV_W-1:0] intv_reg;
    logic [CW-1:0]              thr_hi_reg;
    logic [CW-1:0]              thr_lo_reg;

    // window state
    logic [SW-1:0]  window_reg [ata_pkg::WINDOW_LENGTH];
    logic [PW-1:0]  pos_reg;
    logic [PW-1:0]  pos_next;
    logic [SMW-1:0] sum_reg;
    logic [SMW-1:0] sum_next;

    // alarm state
    logic          alarm_reg;
    logic          alarm_next;
    logic [DW-1:0] dur_reg;
    logic [DW-1:0] dur_next;

    // pipeline
    logic                  s1_valid_reg;
    logic [SMW-1:0]        s1_sum_reg;
    logic                  s2_valid_reg;
    logic [PRW-1:0]        s2_p_reg;
    logic                  s3_valid_reg;
    logic [PRW-1:0]        s3_p_reg;
    logic [AW-1:0]         s3_q_reg;
    ata_pkg::alarm_t       s3_alarm_reg;
    logic                  out_valid_reg;
    logic [AW-1:0]         out_avg_reg;
    ata_pkg::alarm_t       out_alarm_reg;

    logic ready_out;
    logic ready3;
    logic ready2;
    logic ready1;
    logic s_accept;

    logic [SW-1:0]      sample;
    logic [CW-1:0]      scaled;
    logic               above;
    logic               below;
    logic               raised;
    logic               cleared;
    logic               flag_mid;
    logic [DW-1:0]      dur_base;
    logic [DW:0]        dur_sum;
    ata_pkg::alarm_t    alarm_now;
    logic [PRW+MW-1:0]  q_prod;
    logic [PRW+MW-1:0]  q_shift;
    logic [AW-1:0]      q_est;
    logic [PRW-1:0]     q_den;
    logic [PRW-1:0]     q_rem;
    logic [AW-1:0]      avg_fix;

    assign ready_out = !out_valid_reg || m_tready;
    assign ready3    = !s3_valid_reg || ready_out;
    assign ready2    = !s2_valid_reg || ready3;
    assign ready1    = !s1_valid_reg || ready2;
    assign s_tready  = ready1;
    assign s_accept  = s_tvalid && ready1;
    assign cfg_ready = 1'b1;

    assign sample = s_tdata[SW-1:0];

    always_comb
    begin
        sum_next = sum_reg - SMW'(window_reg[pos_reg]) + SMW'(sample);
        if (pos_reg == PW'(ata_pkg::WINDOW_LENGTH - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
        end
    end

    // hysteresis decision and duration update
    always_comb
    begin
        scaled   = CW'({s2_p_reg, 4'b0000}) + CW'({s2_p_reg, 2'b00});
        above    = scaled > thr_hi_reg;
        below    = scaled < thr_lo_reg;
        raised   = above && !alarm_reg;
        flag_mid = alarm_reg || raised;
        cleared  = below && flag_mid;
        alarm_next = flag_mid && !cleared;
        dur_base = raised ? '0 : dur_reg;
        dur_sum  = {1'b0, dur_base} + (DW + 1)'(intv_reg);
        if (!alarm_next)
        begin
            dur_next = dur_base;
        end
        else if (dur_sum[DW])
        begin
            dur_next = '1;
        end
        else
        begin
            dur_next = dur_sum[DW-1:0];
        end
        alarm_now.duration = dur_next;
        alarm_now.cleared  = cleared;
        alarm_now.raised   = raised;
        alarm_now.active   = alarm_next;
    end

    // average: reciprocal estimate, then one correction step
    assign q_prod  = s2_p_reg * RECIP_M_C;
    assign q_shift = q_prod >> ata_pkg::RECIP_K;
    assign q_est   = q_shift[AW-1:0];
    assign q_den   = PRW'(s3_q_reg) * DEN_C;
    assign q_rem   = s3_p_reg - q_den;
    assign avg_fix = (q_rem >= DEN_C) ? s3_q_reg + AW'(1) : s3_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= ata_pkg::THR_RESET;
            intv_reg   <= ata_pkg::INTV_RESET;
            thr_hi_reg <= CW'(longint'(ata_pkg::THR_RESET) * ata_pkg::THR_HI_K);
            thr_lo_reg <= CW'(longint'(ata_pkg::THR_RESET) * ata_pkg::THR_LO_K);
            for (int i = 0; i < ata_pkg::WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
            pos_reg       <= '0;
            sum_reg       <= '0;
            alarm_reg     <= 1'b0;
            dur_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    ata_pkg::CFG_THRESHOLD: thr_reg  <= cfg_data[ata_pkg::THR_W-1:0];
                    ata_pkg::CFG_INTERVAL:  intv_reg <= cfg_data[ata_pkg::INTV_W-1:0];
                    default: ;
                endcase
            end
            thr_hi_reg <= CW'(thr_reg) * THR_HI_C;
            thr_lo_reg <= CW'(thr_reg) * THR_LO_C;

            if (s_accept)
            begin
                window_reg[pos_reg] <= sample;
                pos_reg             <= pos_next;
                sum_reg             <= sum_next;
            end
            if (s2_valid_reg && ready3)
            begin
                alarm_reg <= alarm_next;
                dur_reg   <= dur_next;
            end

            if (ready1)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_sum_reg <= sum_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_p_reg <= PRW'(s1_sum_reg) * PRW'(ata_pkg::MV_NUM);
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_p_reg     <= s2_p_reg;
            s3_q_reg     <= q_est;
            s3_alarm_reg <= alarm_now;
        end
        if (ready_out && s3_valid_reg)
        begin
            out_avg_reg   <= avg_fix;
            out_alarm_reg <= s3_alarm_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_alarm_reg.duration, out_alarm_reg.cleared,
                       out_alarm_reg.raised, out_alarm_reg.active, out_avg_reg};

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SMW'(ata_pkg::SUM_MAX))
        else $error("window sum beyond full scale");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(ata_pkg::WINDOW_LENGTH - 1))
        else $error("write position beyond window");

    a_alarm_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s2_valid_reg && ready3) |=> $stable(alarm_reg) && $stable(dur_reg))
        else $error("alarm state changed without an item");

    a_raise_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_alarm_reg.raised |-> out_alarm_reg.active
                                               && !out_alarm_reg.cleared)
        else $error("raise without active alarm");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_alarm_reg.cleared |-> !out_alarm_reg.active)
        else $error("clear with alarm still active");

endmodule

FILE: verif/tb_averaged_threshold_alarm.sv
module tb_averaged_threshold_alarm;

    localparam longint unsigned MV_SCALE    = 3675;
    localparam longint unsigned ADC_FULL    = 4095;
    localparam int unsigned     DRAIN_CYCLES = 8;
    localparam int unsigned     CYCLE_LIMIT  = 400000;
    localparam int unsigned     RESULT_W     = ata_pkg::DUR_W + 3 + ata_pkg::AVG_W;

    typedef struct packed {
        ata_pkg::alarm_t                status;
        logic [ata_pkg::AVG_W-1:0]      avg_mv;
    } alarm_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [ata_pkg::IN_DATA_W-1:0]      s_tdata;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [ata_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [ata_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [ata_pkg::CFG_DATA_W-1:0]     cfg_data;

    // predicted state of the alarm
    logic [ata_pkg::SAMPLE_W-1:0]       ring [ata_pkg::WINDOW_LENGTH];
    int unsigned                        ring_pos;
    longint unsigned                    ring_sum;
    bit                                 alarm_on;
    logic [ata_pkg::DUR_W-1:0]          dur_ms;
    logic [ata_pkg::THR_W-1:0]          thr_mv;
    logic [ata_pkg::INTV_W-1:0]         intv_ms;

    alarm_result_t             pending_results [$];
    int unsigned               mismatch_count = 0;
    int unsigned               cycle_count = 0;
    int unsigned               send_idle_pct = 0;
    int unsigned               recv_stall_pct = 0;
    int unsigned               holdoff_left = 0;

    averaged_threshold_alarm i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: a hold-off counts down first, otherwise stall at random
    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(alarm_result_t'(m_tdata[RESULT_W-1:0]));
    end

    function automatic void reset_prediction();
        int i;
        for (i = 0; i < ata_pkg::WINDOW_LENGTH; i++)
            ring[i] = '0;
        ring_pos = 0;
        ring_sum = 0;
        alarm_on = 1'b0;
        dur_ms   = '0;
        thr_mv   = ata_pkg::THR_RESET;
        intv_ms  = ata_pkg::INTV_RESET;
    endfunction

    function automatic void predict_alarm(input logic [ata_pkg::SAMPLE_W-1:0] smp);
        alarm_result_t   r;
        longint unsigned scaled;
        longint unsigned thr_scaled;
        longint unsigned grown;
        longint unsigned avg_full;
        bit              above;
        bit              below;
        r = '0;
        ring_sum = ring_sum - ring[ring_pos] + smp;
        ring[ring_pos] = smp;
        ring_pos = (ring_pos + 1 >= ata_pkg::WINDOW_LENGTH) ? 0 : ring_pos + 1;

        // exact hysteresis: average against 21/20 and 19/20 of the threshold
        scaled     = ring_sum * MV_SCALE * 20;
        thr_scaled = thr_mv;
        thr_scaled = thr_scaled * ADC_FULL * ata_pkg::WINDOW_LENGTH;
        above = scaled > thr_scaled * 21;
        below = scaled < thr_scaled * 19;

        if (above && !alarm_on)
        begin
            alarm_on = 1'b1;
            dur_ms   = '0;
            r.status.raised = 1'b1;
        end
        if (below && alarm_on)
        begin
            alarm_on = 1'b0;
            r.status.cleared = 1'b1;
        end
        if (alarm_on)
        begin
            grown = dur_ms;
            grown = grown + intv_ms;
            dur_ms = (grown > 64'hFFFF_FFFF) ? '1 : grown[ata_pkg::DUR_W-1:0];
        end

        avg_full          = (ring_sum * MV_SCALE) / (ADC_FULL * ata_pkg::WINDOW_LENGTH);
        r.avg_mv          = avg_full[ata_pkg::AVG_W-1:0];
        r.status.active   = alarm_on;
        r.status.duration = dur_ms;
        pending_results.push_back(r);
    endfunction

    function automatic void note_mismatch(input string what, input longint unsigned want,
                                          input longint unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $time);
    endfunction

    task automatic check_result(input alarm_result_t got);
        alarm_result_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch("result with none outstanding, fields", 0, got);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.avg_mv !== want.avg_mv)
                note_mismatch("average_mv", want.avg_mv, got.avg_mv);
            if (got.status.active !== want.status.active)
                note_mismatch("alarm_active", want.status.active, got.status.active);
            if (got.status.raised !== want.status.raised)
                note_mismatch("alarm_raised", want.status.raised, got.status.raised);
            if (got.status.cleared !== want.status.cleared)
                note_mismatch("alarm_cleared", want.status.cleared, got.status.cleared);
            if (got.status.duration !== want.status.duration)
                note_mismatch("alarm_duration_ms", want.status.duration,
                              got.status.duration);
        end
    endtask

    function automatic int draw_gap(input int unsigned pct);
        int n;
        n = 0;
        while (n < 16 && $urandom_range(99) < pct)
            n++;
        return n;
    endfunction

    task automatic send_sample(input logic [ata_pkg::SAMPLE_W-1:0] smp);
        int gap;
        gap = draw_gap(send_idle_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {{(ata_pkg::IN_DATA_W-ata_pkg::SAMPLE_W){1'b0}}, smp};
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_alarm(smp);
    endtask

    // drop valid, then hold until every outstanding result has been checked
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ata_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [ata_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ata_pkg::CFG_THRESHOLD: thr_mv  = value[ata_pkg::THR_W-1:0];
            ata_pkg::CFG_INTERVAL:  intv_ms = value[ata_pkg::INTV_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // reset settings: full-scale samples raise, zeros bring the average back down
    task automatic test_default_alarm_cycle();
        int i;
        for (i = 0; i < 4; i++)
            send_sample(12'd4095);
        for (i = 0; i < 5; i++)
            send_sample(12'd0);
    endtask

    // exact band edges: sum 117 sits on 1.05*20, sum 741 on 0.95*140
    task automatic test_hysteresis_edges();
        wait_idle();
        write_register(ata_pkg::CFG_THRESHOLD, 16'd20);
        send_sample(12'd23);
        send_sample(12'd23);
        send_sample(12'd23);
        send_sample(12'd24);
        send_sample(12'd24);
        send_sample(12'd24);
        send_sample(12'd148);
        send_sample(12'd148);
        send_sample(12'd148);
        send_sample(12'd148);
        send_sample(12'd149);
        wait_idle();
        write_register(ata_pkg::CFG_THRESHOLD, 16'd140);
        send_sample(12'd148);
        send_sample(12'd147);
    endtask

    // zero threshold with zero interval, then a masked threshold above range
    task automatic test_register_extremes();
        wait_idle();
        write_register(ata_pkg::CFG_THRESHOLD, 16'd0);
        write_register(ata_pkg::CFG_INTERVAL, 16'd0);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd0);
        wait_idle();
        write_register(ata_pkg::CFG_THRESHOLD, 16'hFFFF);
        write_register(ata_pkg::CFG_INTERVAL, 16'hFFFF);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd4095);
    endtask

    task automatic test_backpressure();
        int i;
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_left   = 300;
        for (i = 0; i < 40; i++)
            send_sample(12'($urandom_range(4095)));
        wait_idle();
    endtask

    // largest interval under a zero threshold keeps the duration growing every tick
    task automatic test_long_alarm();
        int i;
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_register(ata_pkg::CFG_THRESHOLD, 16'd0);
        write_register(ata_pkg::CFG_INTERVAL, 16'd65535);
        for (i = 0; i < 16; i++)
            send_sample(12'($urandom_range(1, 4095)));
    endtask

    // levels that drift across the hysteresis band, with some noise samples
    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
        int unsigned                    sent;
        int unsigned                    seg_len;
        int unsigned                    k;
        int unsigned                    pick;
        int                             centre;
        int                             level;
        int                             v;
        logic [ata_pkg::THR_W-1:0]      thr;
        logic [ata_pkg::INTV_W-1:0]     intv;
        wait_idle();
        pick = $urandom_range(9);
        thr  = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd3675 : (pick == 2) ? 12'd4095 :
               12'($urandom_range(50, 3675));
        pick = $urandom_range(9);
        intv = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'd65535 :
               16'($urandom_range(1, 65535));
        write_register(ata_pkg::CFG_THRESHOLD, {4'($urandom), thr});
        write_register(ata_pkg::CFG_INTERVAL, intv);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        centre = int'(thr) * 4095 / 3675;
        sent = 0;
        while (sent < count)
        begin
            seg_len = $urandom_range(4, 16);
            level   = centre * int'($urandom_range(80, 125)) / 100;
            for (k = 0; k < seg_len && sent < count; k++)
            begin
                if ($urandom_range(9) == 0)
                    v = $urandom_range(4095);
                else
                    v = level + int'($urandom_range(60)) - 30;
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                send_sample(12'(v));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = ata_pkg::CFG_THRESHOLD;
        cfg_data  = '0;
        reset_prediction();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_alarm_cycle();
        test_hysteresis_edges();
        test_register_extremes();
        test_backpressure();
        test_long_alarm();
        test_random_phase(0, 0, 120);
        test_random_phase(61, 0, 120);
        test_random_phase(0, 61, 120);
        test_random_phase(38, 38, 120);
        test_random_phase(0, 0, 120);
        test_random_phase(61, 0, 120);
        test_random_phase(0, 61, 120);
        test_random_phase(38, 38, 120);

        recv_stall_pct = 0;
        wait_idle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
